[rtl/core/dqe_pkg.sv]
// ----------------------------------------------------------------------------
// dqe_pkg
// Shared types and constants for the DNS question encoder: payload structs,
// command kinds passed from front to back, back-end states and trailer bytes.
// ----------------------------------------------------------------------------
package dqe_pkg;

    // Label buffer capacity in characters (1 to 255).
    localparam int LABEL_BYTES = 32;
    localparam int CNT_W       = $clog2(LABEL_BYTES + 1);
    localparam int IDX_W       = (LABEL_BYTES > 1) ? $clog2(LABEL_BYTES) : 1;

    localparam logic [7:0]  SEPARATOR   = 8'd46;
    localparam logic [7:0]  NAME_END    = 8'd0;
    localparam logic [15:0] INET_QCLASS = 16'd1;

    // Trailer: zero byte, qtype high, qtype low, class high, class low.
    localparam int TRL_BYTES = 5;
    localparam logic [2:0] TRL_LAST = 3'(TRL_BYTES - 1);

    typedef struct packed {
        logic [7:0]  ch;
        logic [15:0] qtype;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       overflow;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_CHAR,
        CMD_SEP,
        CMD_END
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  ch;
        logic [15:0] qtype;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LEN,
        BK_RD,
        BK_CHR,
        BK_TRL
    } bk_state_t;

    function automatic logic [7:0] trl_byte(input logic [2:0] idx,
                                            input logic [15:0] qtype);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h00;
            3'd1:    b = qtype[15:8];
            3'd2:    b = qtype[7:0];
            3'd3:    b = INET_QCLASS[15:8];
            default: b = INET_QCLASS[7:0];
        endcase
        return b;
    endfunction

endpackage

[rtl/core/dqe_front.sv]
// ----------------------------------------------------------------------------
// dqe_front
// Accepts name characters, classifies each as label character, separator or
// terminator, and holds the commands in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module dqe_front
    import dqe_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    output logic     q_valid,
    input  logic     q_ready,
    output cmd_t     q_cmd
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    cmd_t       cmd_in;
    logic       push, pop;

    always_comb begin
        cmd_in.ch    = s_data.ch;
        cmd_in.qtype = s_data.qtype;
        unique case (s_data.ch)
            NAME_END:  cmd_in.kind = CMD_END;
            SEPARATOR: cmd_in.kind = CMD_SEP;
            default:   cmd_in.kind = CMD_CHAR;
        endcase
    end

    assign s_ready = (fill_reg != 2'd2);
    assign q_valid = (fill_reg != 2'd0);
    assign q_cmd   = entry_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

[rtl/core/dqe_back.sv]
// ----------------------------------------------------------------------------
// dqe_back
// Executes queued commands: buffers label characters, emits each label as a
// length byte and its characters, and emits the question trailer.
// ----------------------------------------------------------------------------
module dqe_back
    import dqe_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_valid,
    output logic      q_ready,
    input  cmd_t      q_cmd,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic [7:0]       store_mem [LABEL_BYTES];
    logic [7:0]       rdata_reg;

    bk_state_t        state_reg, state_next;
    cmd_kind_t        kind_reg, kind_next;
    logic [15:0]      qtype_reg, qtype_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             ovf_reg, ovf_next;
    logic [2:0]       trl_reg, trl_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_data_reg, m_data_next;

    logic             out_free;
    logic             out_load;
    logic             wr_en;
    logic [CNT_W-1:0] last_idx;

    assign out_free = !m_valid_reg || m_ready;
    assign last_idx = count_reg - CNT_W'(1);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    unique case (q_cmd.kind)
                        CMD_SEP:  state_next = BK_LEN;
                        CMD_END:  state_next = (count_reg != '0) ? BK_LEN : BK_TRL;
                        default:  state_next = BK_IDLE;
                    endcase
                end
            end
            BK_LEN: begin
                if (out_free) begin
                    state_next = (count_reg == '0) ? BK_IDLE : BK_RD;
                end
            end
            BK_RD: begin
                state_next = BK_CHR;
            end
            BK_CHR: begin
                if (out_free) begin
                    if (idx_reg == last_idx) begin
                        state_next = (kind_reg == CMD_SEP) ? BK_IDLE : BK_TRL;
                    end else begin
                        state_next = BK_RD;
                    end
                end
            end
            BK_TRL: begin
                if (out_free && trl_reg == TRL_LAST) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        q_ready     = 1'b0;
        wr_en       = 1'b0;
        out_load    = 1'b0;
        kind_next   = kind_reg;
        qtype_next  = qtype_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        ovf_next    = ovf_reg;
        trl_next    = trl_reg;
        m_data_next = m_data_reg;
        unique case (state_reg)
            BK_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    kind_next  = q_cmd.kind;
                    qtype_next = q_cmd.qtype;
                    idx_next   = '0;
                    trl_next   = '0;
                    if (q_cmd.kind == CMD_CHAR) begin
                        if (count_reg < CNT_W'(LABEL_BYTES)) begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end else if (q_cmd.kind == CMD_END && count_reg == '0) begin
                        ovf_next = 1'b0;
                    end
                end
            end
            BK_LEN: begin
                if (out_free) begin
                    out_load             = 1'b1;
                    m_data_next.out_byte = 8'(count_reg);
                    m_data_next.run_last = (count_reg == '0) && (kind_reg == CMD_SEP);
                    m_data_next.overflow = ovf_reg;
                    if (count_reg == '0) begin
                        ovf_next = 1'b0;
                    end
                end
            end
            BK_CHR: begin
                if (out_free) begin
                    out_load             = 1'b1;
                    m_data_next.out_byte = rdata_reg;
                    m_data_next.run_last = (idx_reg == last_idx) && (kind_reg == CMD_SEP);
                    m_data_next.overflow = ovf_reg;
                    idx_next             = idx_reg + CNT_W'(1);
                    if (idx_reg == last_idx) begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end
                end
            end
            BK_TRL: begin
                if (out_free) begin
                    out_load             = 1'b1;
                    m_data_next.out_byte = trl_byte(trl_reg, qtype_reg);
                    m_data_next.run_last = (trl_reg == TRL_LAST);
                    m_data_next.overflow = 1'b0;
                    trl_next             = trl_reg + 3'd1;
                end
            end
            default: begin
            end
        endcase
        m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        qtype_reg  <= qtype_next;
        idx_reg    <= idx_next;
        trl_reg    <= trl_next;
        m_data_reg <= m_data_next;
    end

    // Label buffer: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[count_reg[IDX_W-1:0]] <= q_cmd.ch;
        end
        rdata_reg <= store_mem[idx_reg[IDX_W-1:0]];
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(LABEL_BYTES))
        else $error("label count beyond capacity");

    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> (count_reg == CNT_W'(LABEL_BYTES)))
        else $error("overflow flag set on a label that is not full");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && m_valid_reg) |-> m_ready)
        else $error("output byte overwritten before transfer");

    a_chr_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_CHR || state_reg == BK_RD) |-> (count_reg != '0))
        else $error("character emission on an empty label");

endmodule

[rtl/core/dns_question_encoder_core.sv]
// ----------------------------------------------------------------------------
// dns_question_encoder_core
// Encodes a dotted domain name, one character per transfer, into DNS
// question wire form: length-prefixed labels, zero byte, qtype, class IN.
// ----------------------------------------------------------------------------
//
//  channel | ports                      | carries
//  --------+----------------------------+------------------------------------
//  input   | s_valid, s_ready, s_data   | ch (name character), qtype
//  result  | m_valid, m_ready, m_data   | out_byte, run_last, overflow
//
// A label character is buffered by the back end when its command is taken.
// Each emitted label character takes a buffer read, then an output register
// load; the length byte and each trailer byte load the output register
// directly. The registered buffer read sets the per-character emission rate.
// The front queue holds two commands, so input transfers continue while the
// back end emits until it fills; a stalled result side then stalls input too.
// aresetn is synchronous and active low; it clears the queue, the label count,
// the overflow flag and the output valid. Buffer contents are not cleared.
//
module dns_question_encoder_core
    import dqe_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    // Command queue between the classifier and the emitter
    logic q_valid;
    logic q_ready;
    cmd_t q_cmd;

    // Classify input transfers and queue them
    dqe_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_cmd   (q_cmd)
    );

    // Buffer labels and emit the encoded bytes
    dqe_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_cmd   (q_cmd),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
